FILE: rtl/gfpe_pkg.sv
// -----------------------------------------------------------------------------
// GF(2^8) polynomial evaluator package
// Field constants and the request record shared by the evaluator modules.
// -----------------------------------------------------------------------------
package gfpe_pkg;

   localparam int unsigned GF_WIDTH   = 8;
   localparam logic [8:0]  GF_POLY    = 9'h163;
   localparam int unsigned GF_TOP_BIT = GF_WIDTH - 1;

   typedef logic [GF_WIDTH-1:0] gf_elem_type;

   typedef struct packed {
      gf_elem_type coefficient;
      gf_elem_type point;
      logic        last_term;
   } gfpe_term_type;

endpackage

FILE: rtl/gf256_polynomial_evaluator.sv
// A request is registered in the stage register at acceptance; its result, when it
// carries the last term, moves to the response register once that register is free.
// Throughput: one request per cycle unless a response stalls, with combinational multiplies.
// Reset clears both pipeline stages, the running sum to 0 and the point power to 1.
// -----------------------------------------------------------------------------
// GF(2^8) polynomial evaluator
// Streams coefficients lowest degree first and returns p(x) on the last term.
// -----------------------------------------------------------------------------
module gf256_polynomial_evaluator
   import gfpe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_coefficient,
   input  logic [7:0]  req_point,
   input  logic        req_last_term,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_value
);

   logic          stage_valid_ff;
   logic          stage_valid_in;
   gfpe_term_type stage_term_ff;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   gf_elem_type   rsp_value_ff;
   gf_elem_type   sum;
   logic          advance;
   logic          step;
   logic          req_accept;

   assign advance    = !rsp_valid_ff || rsp_ready;
   assign step       = stage_valid_ff && advance;
   assign req_ready  = !reset && (!stage_valid_ff || advance);
   assign req_accept = req_valid && req_ready;

   gfpe_accum u_accum (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .term  (stage_term_ff),
      .sum   (sum)
   );

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_accept) begin
         stage_valid_in = 1'b1;
      end else if (step) begin
         stage_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = step && stage_term_ff.last_term;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_term_ff.coefficient <= req_coefficient;
         stage_term_ff.point       <= req_point;
         stage_term_ff.last_term   <= req_last_term;
      end
      if (step && stage_term_ff.last_term) begin
         rsp_value_ff <= sum;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

endmodule

FILE: rtl/gfpe_mul.sv
// -----------------------------------------------------------------------------
// GF(2^8) multiplier
// Combinational shift-and-add product reduced by x^8 + x^6 + x^5 + x + 1.
// -----------------------------------------------------------------------------
module gfpe_mul
   import gfpe_pkg::*;
(
   input  gf_elem_type lhs,
   input  gf_elem_type rhs,
   output gf_elem_type product
);

   always_comb begin
      gf_elem_type acc;
      gf_elem_type shifted;
      acc     = '0;
      shifted = lhs;
      for (int bit_idx = 0; bit_idx < GF_WIDTH; bit_idx++) begin
         if (rhs[bit_idx]) begin
            acc = acc ^ shifted;
         end
         if (shifted[GF_TOP_BIT]) begin
            shifted = {shifted[GF_WIDTH-2:0], 1'b0} ^ GF_POLY[GF_WIDTH-1:0];
         end else begin
            shifted = {shifted[GF_WIDTH-2:0], 1'b0};
         end
      end
      product = acc;
   end

endmodule

FILE: rtl/gfpe_accum.sv
// -----------------------------------------------------------------------------
// GF(2^8) polynomial accumulator
// Holds the running sum and the current power of the point, and folds in one
// term per step with two parallel field multiplies.
// -----------------------------------------------------------------------------
module gfpe_accum
   import gfpe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  gfpe_term_type term,
   output gf_elem_type   sum
);

   gf_elem_type running_sum_ff;
   gf_elem_type running_sum_in;
   gf_elem_type point_power_ff;
   gf_elem_type point_power_in;
   gf_elem_type term_product;
   gf_elem_type next_power;

   gfpe_mul u_term_mul (
      .lhs     (term.coefficient),
      .rhs     (point_power_ff),
      .product (term_product)
   );

   gfpe_mul u_power_mul (
      .lhs     (point_power_ff),
      .rhs     (term.point),
      .product (next_power)
   );

   assign sum = running_sum_ff ^ term_product;

   // The last term of a block returns the accumulator to its starting state.
   always_comb begin
      running_sum_in = running_sum_ff;
      point_power_in = point_power_ff;
      if (step) begin
         if (term.last_term) begin
            running_sum_in = '0;
            point_power_in = gf_elem_type'(1);
         end else begin
            running_sum_in = sum;
            point_power_in = next_power;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_sum_ff <= '0;
         point_power_ff <= gf_elem_type'(1);
      end else begin
         running_sum_ff <= running_sum_in;
         point_power_ff <= point_power_in;
      end
   end

endmodule

FILE: rtl/gfpe_checker.sv
// -----------------------------------------------------------------------------
// GF(2^8) polynomial evaluator port checker
// Watches the evaluator's ports for pipeline and handshake consistency.
// -----------------------------------------------------------------------------
module gfpe_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_last_term,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_value
);

   // A response that is not taken stays on the port unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
      else $error("response dropped or changed while stalled");

   // Reset leaves no response pending.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response pending after reset");

   // With the output register empty the pipeline always takes a request.
   assert property (@(posedge clock) disable iff (reset) !rsp_valid |-> req_ready)
      else $error("request refused while output register is empty");

   // A new response must follow an accepted last-term request.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_last_term, 2))
      else $error("response without a matching last-term request");

endmodule

bind gf256_polynomial_evaluator gfpe_checker u_gfpe_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_last_term (req_last_term),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_value     (rsp_value)
);

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// GF(2^8) polynomial evaluator testbench
// Streams coefficient requests lowest degree first and predicts each p(x)
// with a GF(2^8) multiplier of its own. Directed tests cover field extremes,
// a zero point, the reduction path, single-term polynomials and a point that
// changes within a polynomial. Random polynomials follow, with random idling
// on both sides. A closing phase runs at full rate with no idling.
// -----------------------------------------------------------------------------
module tb_top;
   import gfpe_pkg::*;

   localparam int          IDLE_LIMIT    = 2000;
   localparam int          TAIL_CYCLES   = 10;
   localparam gf_elem_type REDUCTION_LOW = GF_POLY[GF_WIDTH-1:0];

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   gf_elem_type req_coefficient;
   gf_elem_type req_point;
   logic        req_last_term;
   logic        rsp_valid;
   logic        rsp_ready;
   gf_elem_type rsp_value;

   gf_elem_type expected_values[$];
   gf_elem_type eval_sum;
   gf_elem_type eval_power;
   bit          source_idle_on;
   bit          sink_idle_on;
   int          fail_count;
   int          request_count;
   int          block_count;
   int          checked_count;
   int          idle_cycles;

   gf256_polynomial_evaluator u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_coefficient (req_coefficient),
      .req_point       (req_point),
      .req_last_term   (req_last_term),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_value       (rsp_value)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic gf_elem_type gf_product(input gf_elem_type lhs, input gf_elem_type rhs);
      gf_elem_type a;
      gf_elem_type acc;
      a   = lhs;
      acc = '0;
      for (int i = 0; i < GF_WIDTH; i++) begin
         if (rhs[i]) begin
            acc ^= a;
         end
         if (a[GF_TOP_BIT]) begin
            a = (a << 1) ^ REDUCTION_LOW;
         end else begin
            a = a << 1;
         end
      end
      return acc;
   endfunction

   function automatic gf_elem_type pick_elem();
      case ($urandom_range(0, 9))
         0: begin
            return 8'h00;
         end
         1: begin
            return 8'hff;
         end
         2: begin
            return 8'h01;
         end
         default: begin
            return gf_elem_type'($urandom);
         end
      endcase
   endfunction

   task automatic update_polynomial(input gf_elem_type coef, input gf_elem_type pt,
                                    input logic last);
      gf_elem_type sum;
      sum = eval_sum ^ gf_product(coef, eval_power);
      request_count++;
      if (last) begin
         expected_values.push_back(sum);
         eval_sum   = '0;
         eval_power = 8'h01;
         block_count++;
      end else begin
         eval_sum   = sum;
         eval_power = gf_product(eval_power, pt);
      end
   endtask

   task automatic send_term(input gf_elem_type coef, input gf_elem_type pt, input logic last);
      @(negedge clock);
      if (source_idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_coefficient <= coef;
      req_point       <= pt;
      req_last_term   <= last;
      do @(posedge clock); while (!req_ready);
      update_polynomial(coef, pt, last);
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_values.size() != 0) @(posedge clock);
   endtask

   task automatic send_random_blocks(input int item_total, input bit with_pauses);
      int sent;
      int len;
      int blocks;
      bit wander;
      gf_elem_type pt;
      sent   = 0;
      blocks = 0;
      while (sent < item_total) begin
         if ($urandom_range(0, 9) == 0) begin
            len = $urandom_range(9, 40);
         end else begin
            len = $urandom_range(1, 8);
         end
         wander = ($urandom_range(0, 7) == 0);
         pt     = pick_elem();
         for (int i = 0; i < len; i++) begin
            if (wander) begin
               pt = pick_elem();
            end
            send_term(pick_elem(), pt, i == len - 1);
         end
         sent += len;
         blocks++;
         if (with_pauses && blocks % 40 == 0) begin
            wait_for_results();
         end
      end
   endtask

   task automatic test_single_term();
      send_term(8'h00, 8'h00, 1'b1);
      send_term(8'hff, 8'hff, 1'b1);
      send_term(8'h01, 8'h80, 1'b1);
      send_term(8'h80, 8'h01, 1'b1);
      wait_for_results();
   endtask

   task automatic test_zero_point();
      send_term(8'h5a, 8'h00, 1'b0);
      send_term(8'hff, 8'h00, 1'b0);
      send_term(8'h13, 8'h00, 1'b1);
      wait_for_results();
   endtask

   task automatic test_field_extremes();
      for (int i = 0; i < 4; i++) begin
         send_term(8'hff, 8'hff, i == 3);
      end
      send_term(8'h01, 8'h80, 1'b0);
      send_term(8'h80, 8'h80, 1'b0);
      send_term(8'hff, 8'h80, 1'b1);
      wait_for_results();
   endtask

   task automatic test_point_change();
      send_term(8'h11, 8'h02, 1'b0);
      send_term(8'h22, 8'h80, 1'b0);
      send_term(8'h33, 8'hff, 1'b0);
      send_term(8'h44, 8'h00, 1'b1);
      wait_for_results();
   endtask

   task automatic test_random_polynomials();
      send_random_blocks(1450, 1'b1);
      wait_for_results();
   endtask

   task automatic test_full_rate();
      source_idle_on = 1'b0;
      sink_idle_on   = 1'b0;
      send_random_blocks(180, 1'b0);
      wait_for_results();
   endtask

   initial begin
      rsp_ready = 1'b1;
      forever begin
         @(negedge clock);
         if (sink_idle_on && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_values.size() == 0) begin
            $error("value: unexpected result, actual %02h", rsp_value);
            fail_count++;
         end else begin
            if (rsp_value !== expected_values[0]) begin
               $error("value mismatch: expected %02h, actual %02h",
                      expected_values[0], rsp_value);
               fail_count++;
            end
            void'(expected_values.pop_front());
            checked_count++;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Watchdog expired with %0d results outstanding.", expected_values.size());
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_coefficient = '0;
      req_point       = '0;
      req_last_term   = 1'b0;
      eval_sum        = '0;
      eval_power      = 8'h01;
      source_idle_on  = 1'b1;
      sink_idle_on    = 1'b1;
      fail_count      = 0;
      request_count   = 0;
      block_count     = 0;
      checked_count   = 0;
      idle_cycles     = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_single_term();
      test_zero_point();
      test_field_extremes();
      test_point_change();
      test_random_polynomials();
      test_full_rate();

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Sent %0d coefficient requests forming %0d polynomials.",
               request_count, block_count);
      $display("Checked %0d results, %0d mismatches.", checked_count, fail_count);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/gfpe_pkg.sv
rtl/gfpe_mul.sv
rtl/gfpe_accum.sv
rtl/gf256_polynomial_evaluator.sv
rtl/gfpe_checker.sv
verif/tb_top.sv
